FILE: design/pee_pkg.sv
package pee_pkg;

    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STATUS_W        = 3;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_DIVZERO = 3'd1,
        STAT_UNDER   = 3'd2,
        STAT_OVER    = 3'd3,
        STAT_INVALID = 3'd4
    } status_t;

endpackage

FILE: design/postfix_expression_evaluator.sv
// An accepted digit or a rejected symbol leaves the block idle; + - * pass through S_READ (stack RAM read).
// A '/' waits in S_DIV for the bit-per-cycle divider; '/' by zero with a deeper stack goes through S_REFILL.
// A beat with tlast then passes through S_EMIT, which loads the result register once the output is free.
// Input is accepted only in S_IDLE, so a new symbol waits until the previous one has been evaluated.
// Reset clears the stack count, the error code, the state and the output valid;
// the stack RAM is not cleared and needs no clearing pass.
module postfix_expression_evaluator
    import pee_pkg::*;
    #(
        parameter int STACK_DEPTH = STACK_DEPTH_DEF
    )
    (
        input  logic        aclk,
        input  logic        aresetn,
        input  logic        s_tvalid,
        output logic        s_tready,
        input  logic [7:0]  s_tdata,   // [7:0] symbol
        input  logic        s_tlast,
        output logic        m_tvalid,
        input  logic        m_tready,
        output logic [31:0] m_tdata,   // [31:0] value
        output logic [2:0]  m_tuser    // [2:0] status
    );

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_DIV, S_REFILL, S_EMIT} state_t;
    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic              last_reg, last_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] top_reg, top_next;
    status_t           err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2, cnt_m3;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_q;
    logic [DATA_W-1:0] mul_res;
    state_t            finish_state;

    function automatic status_t sticky(status_t cur, status_t code);
        return (cur == STAT_OK) ? code : cur;
    endfunction

    // top_reg caches the top entry; the RAM holds the entries below it.
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign cnt_m2  = count_reg - CNT_W'(2);
    assign cnt_m3  = count_reg - CNT_W'(3);
    assign mul_res = 32'(rd_data * top_reg);

    pee_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt_m1[ADDR_W-1:0]),
        .wr_data (top_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pee_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rd_data),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        rd_addr         = cnt_m2[ADDR_W-1:0];
        div_start       = 1'b0;
        finish_state    = last_reg ? S_EMIT : S_IDLE;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    last_next  = s_tlast;
                    state_next = s_tlast ? S_EMIT : S_IDLE;
                    if (s_tdata inside {[SYM_ZERO:SYM_NINE]}) begin
                        if (count_reg >= CNT_W'(STACK_DEPTH)) begin
                            err_next = sticky(err_reg, STAT_OVER);
                        end else begin
                            wr_en      = (count_reg != '0);
                            top_next   = DATA_W'(s_tdata - SYM_ZERO);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (s_tdata inside {SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH}) begin
                        if (count_reg < CNT_W'(2)) begin
                            err_next = sticky(err_reg, STAT_UNDER);
                        end else begin
                            state_next = S_READ;
                            case (s_tdata)
                                SYM_PLUS:  op_next = OP_ADD;
                                SYM_MINUS: op_next = OP_SUB;
                                SYM_STAR:  op_next = OP_MUL;
                                default:   op_next = OP_DIV;
                            endcase
                        end
                    end else begin
                        err_next = sticky(err_reg, STAT_INVALID);
                    end
                end
            end
            S_READ: begin
                case (op_reg)
                    OP_ADD: begin
                        top_next   = rd_data + top_reg;
                        count_next = cnt_m1;
                        state_next = finish_state;
                    end
                    OP_SUB: begin
                        top_next   = rd_data - top_reg;
                        count_next = cnt_m1;
                        state_next = finish_state;
                    end
                    OP_MUL: begin
                        top_next   = mul_res;
                        count_next = cnt_m1;
                        state_next = finish_state;
                    end
                    default: begin
                        if (top_reg == '0) begin
                            // Both operands are dropped, so the entry below them becomes the top.
                            err_next   = sticky(err_reg, STAT_DIVZERO);
                            count_next = cnt_m2;
                            rd_addr    = cnt_m3[ADDR_W-1:0];
                            state_next = (count_reg > CNT_W'(2)) ? S_REFILL : finish_state;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    top_next   = div_q;
                    count_next = cnt_m1;
                    state_next = finish_state;
                end
            end
            S_REFILL: begin
                top_next   = rd_data;
                state_next = finish_state;
            end
            S_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_value_next  = (count_reg == '0) ? '0 : top_reg;
                    out_status_next = (count_reg == '0) ? sticky(err_reg, STAT_UNDER) : err_reg;
                    count_next      = '0;
                    err_next        = STAT_OK;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= STAT_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg         <= op_next;
        last_reg       <= last_next;
        top_reg        <= top_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

endmodule

FILE: design/pee_ram.sv
module pee_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 16
    )
    (
        input  logic                     aclk,
        input  logic                     wr_en,
        input  logic [$clog2(DEPTH)-1:0] wr_addr,
        input  logic [WIDTH-1:0]         wr_data,
        input  logic [$clog2(DEPTH)-1:0] rd_addr,
        output logic [WIDTH-1:0]         rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/pee_div.sv
module pee_div
    import pee_pkg::*;
    (
        input  logic              aclk,
        input  logic              aresetn,
        input  logic              start,
        input  logic [DATA_W-1:0] dividend,
        input  logic [DATA_W-1:0] divisor,
        output logic              done,
        output logic [DATA_W-1:0] quotient
    );

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   trial;

    // One restoring step per cycle on the magnitudes; the sign is applied at the end.
    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end else if (busy_reg) begin
            if (!trial[DATA_W]) begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

FILE: design/pee_checker.sv
module pee_checker
    import pee_pkg::*;
    (
        input logic        aclk,
        input logic        aresetn,
        input logic        s_tready,
        input logic        m_tvalid,
        input logic        m_tready,
        input logic [31:0] m_tdata,
        input logic [2:0]  m_tuser
    );

    // A stalled result beat keeps its value and status.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= STAT_INVALID)
        else $error("status code out of range");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A new result is only loaded while the input side is held off.
    a_emit_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while input was open");

endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pee_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int TARGET_BEATS = 1450;
    localparam int QUIET_FROM   = 4000;
    localparam int QUIET_TO     = 9000;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } outcome_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] symbol
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] value
    logic [2:0]  m_tuser;         // [2:0] status

    beat_t       symbols_pending[$];
    outcome_t    results_due[$];
    logic [7:0]  expr_syms[$];

    // Our own copy of the evaluator state.
    logic [31:0] calc_stack[DEPTH];
    int          calc_depth = 0;
    status_t     calc_err   = STAT_OK;

    int cycle_count    = 0;
    int beats_sent     = 0;
    int beats_queued   = 0;
    int results_seen   = 0;
    int expr_count     = 0;
    int wellformed_cnt = 0;
    int fail_count     = 0;
    int status_seen[5] = '{0, 0, 0, 0, 0};

    postfix_expression_evaluator #(.STACK_DEPTH(DEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic bit in_quiet_stretch();
        return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
    endfunction

    // ---------------------------------------------------------------- prediction

    function automatic void note_error(status_t code);
        if (calc_err == STAT_OK)
            calc_err = code;
    endfunction

    // Signed division rounded toward zero; the most negative value over -1 wraps.
    function automatic logic [31:0] quotient_trunc(logic [31:0] num, logic [31:0] den);
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] q;
        mag_n = num[31] ? (32'd0 - num) : num;
        mag_d = den[31] ? (32'd0 - den) : den;
        q = mag_n / mag_d;
        return (num[31] ^ den[31]) ? (32'd0 - q) : q;
    endfunction

    function automatic void apply_symbol(logic [7:0] sym);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] res;
        if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
            if (calc_depth >= DEPTH) begin
                note_error(STAT_OVER);
            end else begin
                calc_stack[calc_depth] = 32'(sym) - 32'(SYM_ZERO);
                calc_depth++;
            end
        end else if (sym != SYM_PLUS && sym != SYM_MINUS &&
                     sym != SYM_STAR && sym != SYM_SLASH) begin
            note_error(STAT_INVALID);
        end else if (calc_depth < 2) begin
            note_error(STAT_UNDER);
        end else begin
            rhs = calc_stack[calc_depth-1];
            lhs = calc_stack[calc_depth-2];
            calc_depth -= 2;
            res = '0;
            case (sym)
                SYM_PLUS:  res = lhs + rhs;
                SYM_MINUS: res = lhs - rhs;
                SYM_STAR:  res = lhs * rhs;
                default: begin
                    if (rhs != 32'd0)
                        res = quotient_trunc(lhs, rhs);
                end
            endcase
            // Division by zero consumes both operands and pushes nothing.
            if (sym == SYM_SLASH && rhs == 32'd0) begin
                note_error(STAT_DIVZERO);
            end else begin
                calc_stack[calc_depth] = res;
                calc_depth++;
            end
        end
    endfunction

    function automatic void predict_beat(beat_t b);
        outcome_t o;
        apply_symbol(b.symbol);
        if (b.last) begin
            o.value = '0;
            if (calc_depth == 0)
                note_error(STAT_UNDER);
            else
                o.value = calc_stack[calc_depth-1];
            o.status = calc_err;
            results_due.push_back(o);
            status_seen[int'(calc_err)]++;
            calc_depth = 0;
            calc_err   = STAT_OK;
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] rand_digit();
        return SYM_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 3))
            0:       return SYM_PLUS;
            1:       return SYM_MINUS;
            2:       return SYM_STAR;
            default: return SYM_SLASH;
        endcase
    endfunction

    task automatic close_expression();
        beat_t b;
        for (int i = 0; i < expr_syms.size(); i++) begin
            b.symbol = expr_syms[i];
            b.last   = (i == expr_syms.size() - 1);
            symbols_pending.push_back(b);
        end
        beats_queued += expr_syms.size();
        expr_count++;
        expr_syms.delete();
    endtask

    // Builds a legal expression into expr_syms without closing it.
    task automatic build_legal(int max_operands, bit push_all_first);
        int n;
        int pushed;
        int depth;
        n = $urandom_range(1, max_operands);
        pushed = 0;
        depth = 0;
        while (pushed < n || depth > 1) begin
            if (pushed < n && (depth < 2 || push_all_first || $urandom_range(0, 1))) begin
                expr_syms.push_back(rand_digit());
                pushed++;
                depth++;
            end else begin
                expr_syms.push_back(rand_operator());
                depth--;
            end
        end
    endtask

    // A chain of multiplies that quickly wraps past 32 bits.
    task automatic build_product(int factors);
        expr_syms.push_back(SYM_ZERO + 8'($urandom_range(7, 9)));
        repeat (factors) begin
            expr_syms.push_back(SYM_ZERO + 8'($urandom_range(2, 9)));
            expr_syms.push_back(SYM_STAR);
        end
    endtask

    task automatic add_most_negative_by_minus_one();
        expr_syms.push_back(SYM_ZERO + 8'd2);
        repeat (10) begin
            expr_syms.push_back(SYM_ZERO + 8'd8);
            expr_syms.push_back(SYM_STAR);
        end
        expr_syms.push_back(SYM_ZERO);
        expr_syms.push_back(SYM_ZERO + 8'd1);
        expr_syms.push_back(SYM_MINUS);
        expr_syms.push_back(SYM_SLASH);
        close_expression();
    endtask

    task automatic add_overflow();
        repeat (DEPTH + $urandom_range(1, 3))
            expr_syms.push_back(rand_digit());
        repeat ($urandom_range(0, DEPTH + 2))
            expr_syms.push_back(rand_operator());
        close_expression();
    endtask

    task automatic add_broken();
        int at;
        build_legal(8, 1'b0);
        at = $urandom_range(0, expr_syms.size() - 1);
        case ($urandom_range(0, 2))
            0: if (expr_syms.size() > 1) expr_syms.delete(at);
            1: expr_syms.insert(at, rand_operator());
            default: expr_syms.insert(at, 8'($urandom_range(0, 255)));
        endcase
        close_expression();
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 1))
                expr_syms.push_back(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1))
                expr_syms.push_back(rand_digit());
            else
                expr_syms.push_back(rand_operator());
        end
        close_expression();
    endtask

    task automatic add_directed();
        // Subtract, multiply and divide: ((9 - 8) * 7) / 3.
        expr_syms = '{SYM_ZERO + 8'd9, SYM_ZERO + 8'd8, SYM_MINUS, SYM_ZERO + 8'd7,
                      SYM_STAR, SYM_ZERO + 8'd3, SYM_SLASH};
        close_expression();
        // A negative quotient rounds toward zero.
        expr_syms = '{SYM_ZERO, SYM_ZERO + 8'd9, SYM_MINUS, SYM_ZERO + 8'd2, SYM_SLASH};
        close_expression();
        // Divide by zero stays as the status even after a later bad character.
        expr_syms = '{SYM_ZERO + 8'd5, SYM_ZERO, SYM_SLASH, SYM_ZERO + 8'd3, 8'h00};
        close_expression();
        // Operator on an empty stack, which also ends with nothing on it.
        expr_syms = '{SYM_PLUS};
        close_expression();
        expr_syms = '{SYM_ZERO + 8'd7, 8'hFF};
        close_expression();
    endtask

    task automatic build_stimulus();
        int pick;
        add_directed();
        // Cases that need more beats than the opening set can hold.
        add_overflow();
        add_most_negative_by_minus_one();
        expr_syms.push_back(SYM_ZERO + 8'd9);
        build_legal(DEPTH, 1'b1);
        expr_syms.delete(0);
        close_expression();
        while (beats_queued < TARGET_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                build_legal(8, 1'b0);
                close_expression();
                wellformed_cnt++;
            end else if (pick < 56) begin
                build_legal(DEPTH, 1'($urandom_range(0, 1)));
                close_expression();
                wellformed_cnt++;
            end else if (pick < 64) begin
                build_product($urandom_range(6, 12));
                if ($urandom_range(0, 1)) begin
                    build_product($urandom_range(1, 12));
                    expr_syms.push_back(rand_operator());
                end
                close_expression();
                wellformed_cnt++;
            end else if (pick < 66) begin
                add_most_negative_by_minus_one();
            end else if (pick < 72) begin
                add_overflow();
            end else if (pick < 87) begin
                add_broken();
            end else begin
                add_noise();
            end
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_beat('{symbol: s_tdata, last: s_tlast});
                beats_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (symbols_pending.size() != 0 &&
                    (in_quiet_stretch() || $urandom_range(0, 99) >= 24)) begin
                    beat_t nxt;
                    nxt = symbols_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.symbol;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    $error("unexpected result beat: value %0d status %0d",
                           $signed(m_tdata), m_tuser);
                    fail_count++;
                end else begin
                    outcome_t want;
                    want = results_due.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(want.value), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            m_tready <= in_quiet_stretch() || ($urandom_range(0, 99) >= 24);
        end
    end

    // ---------------------------------------------------------------- control

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out with %0d beats sent and %0d results outstanding.",
                     beats_sent, results_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (beats_sent < beats_queued) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        // Give a stray result the chance to show up.
        repeat (50) @(posedge aclk);
        $display("Evaluated %0d expressions (%0d well formed) from %0d symbols, %0d results.",
                 expr_count, wellformed_cnt, beats_sent, results_seen);
        $display("Status mix: ok %0d, div-by-zero %0d, underflow %0d, overflow %0d, invalid %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
design/pee_pkg.sv
design/pee_ram.sv
design/pee_div.sv
design/postfix_expression_evaluator.sv
design/pee_checker.sv
bench/testbench.sv
